// ===== hw/rtl/rsma_pkg.sv =====
// shared types and constants for the running-sum moving average
`timescale 1ns / 1ps

package rsma_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int SUM_W      = 26;
   localparam int WIN_W      = 11;
   localparam int CNT_W      = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [SAMPLE_W-1:0] FULL_SCALE   = 16'hFFFF;
   localparam logic [WIN_W-1:0]    WINDOW_RESET = 11'd100;
   localparam logic [CNT_W-1:0]    DIV_LAST     = 5'd25;

   // register indexes, taken from paddr[2]
   localparam logic REG_WINDOW = 1'b0;
   localparam logic REG_MODE   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [WIN_W-1:0] window_size;
      logic             complement_mode;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic sum_update;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== hw/rtl/rsma_csr.sv =====
// configuration registers behind the apb-style port
`timescale 1ns / 1ps

module rsma_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rsma_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [rsma_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [rsma_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output rsma_pkg::cfg_type                   cfg
);
   import rsma_pkg::*;

   logic [WIN_W-1:0] window_ff;
   logic             mode_ff;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         mode_ff   <= 1'b0;
      end else if (wr_en) begin
         case (paddr[2])
            REG_WINDOW: window_ff <= pwdata[WIN_W-1:0];
            REG_MODE:   mode_ff   <= pwdata[0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_WINDOW: prdata = {{(CSR_DATA_W-WIN_W){1'b0}}, window_ff};
         REG_MODE:   prdata = {{(CSR_DATA_W-1){1'b0}}, mode_ff};
         default:    prdata = '0;
      endcase
   end

   assign cfg.window_size     = window_ff;
   assign cfg.complement_mode = mode_ff;

endmodule

// ===== hw/rtl/rsma_ctrl.sv =====
// sequencing state machine: accept, sum update, divide, hand over result
`timescale 1ns / 1ps

module rsma_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rsma_pkg::status_type  status,
   output rsma_pkg::cmd_type     cmd
);
   import rsma_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SUM;
         end
         ST_SUM: begin
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall      = 1'b1;
      cmd.accept     = 1'b0;
      cmd.sum_update = 1'b0;
      cmd.div_step   = 1'b0;
      cmd.load_out   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_SUM:    cmd.sum_update = 1'b1;
         ST_DIV:    cmd.div_step   = 1'b1;
         ST_FINISH: cmd.load_out   = status.out_free;
         default:   ;
      endcase
   end

endmodule

// ===== hw/rtl/rsma_datapath.sv =====
// delay store, running sum, restoring divider and output register
`timescale 1ns / 1ps

module rsma_datapath #(
   parameter int MAX_WINDOW = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rsma_pkg::cfg_type              cfg,
   input  rsma_pkg::cmd_type              cmd,
   output rsma_pkg::status_type           status,
   input  logic [rsma_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rsma_pkg::SAMPLE_W-1:0]  rsp_average
);
   import rsma_pkg::*;

   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int PW = AW + 1;
   localparam logic [PW-1:0] DEPTH   = PW'(MAX_WINDOW);
   localparam logic [AW-1:0] LAST_WP = AW'(MAX_WINDOW - 1);

   logic [SAMPLE_W-1:0] mem [MAX_WINDOW];

   logic [AW-1:0]       wp_ff;
   logic                wrapped_ff;
   logic [SAMPLE_W-1:0] rd_ff;
   logic                old_valid_ff;
   logic [SAMPLE_W-1:0] x_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    quo_ff;
   logic [WIN_W-1:0]    rem_ff;
   logic                out_valid_ff;
   logic [SAMPLE_W-1:0] out_avg_ff;

   logic [WIN_W-1:0]    n_eff;
   logic [SAMPLE_W-1:0] x_in;
   logic [PW-1:0]       rp_wide;
   logic [AW-1:0]       rp;
   logic                old_valid_in;
   logic [SUM_W-1:0]    old_ext;
   logic [SUM_W-1:0]    sum_in;
   logic [WIN_W:0]      rem_sh;
   logic [WIN_W:0]      rem_diff;
   logic                q_bit;
   logic [SAMPLE_W-1:0] q_sat;
   logic [SAMPLE_W-1:0] avg_in;

   // window clamped to 1..MAX_WINDOW
   always_comb begin
      n_eff = cfg.window_size;
      if (cfg.window_size == '0) n_eff = WIN_W'(1);
      else if (32'(cfg.window_size) > MAX_WINDOW) n_eff = WIN_W'(MAX_WINDOW);
   end

   assign x_in = cfg.complement_mode ? (FULL_SCALE - req_sample) : req_sample;

   // read slot is n behind the write slot, modulo the store depth
   always_comb begin
      rp_wide = PW'(wp_ff) + DEPTH - PW'(n_eff);
      if (rp_wide >= DEPTH) rp_wide = rp_wide - DEPTH;
      rp = rp_wide[AW-1:0];
   end

   // slots not yet written since reset read as zero
   assign old_valid_in = wrapped_ff || (rp < wp_ff);

   // read-first: with a full-length window the slot is read before overwrite
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_ff      <= mem[rp];
         mem[wp_ff] <= x_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         x_ff         <= x_in;
         old_valid_ff <= old_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else if (cmd.accept) begin
         if (wp_ff == LAST_WP) begin
            wp_ff      <= '0;
            wrapped_ff <= 1'b1;
         end else begin
            wp_ff <= wp_ff + 1'b1;
         end
      end
   end

   assign old_ext = old_valid_ff ? SUM_W'(rd_ff) : '0;
   assign sum_in  = sum_ff + SUM_W'(x_ff) - old_ext;

   always_ff @(posedge clock) begin
      if (reset) sum_ff <= '0;
      else if (cmd.sum_update) sum_ff <= sum_in;
   end

   // one quotient bit a cycle, msb first
   assign rem_sh   = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_diff = rem_sh - {1'b0, n_eff};
   assign q_bit    = (rem_sh >= {1'b0, n_eff});

   always_ff @(posedge clock) begin
      if (cmd.sum_update) begin
         quo_ff <= sum_in;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[SUM_W-2:0], q_bit};
         rem_ff <= q_bit ? rem_diff[WIN_W-1:0] : rem_sh[WIN_W-1:0];
      end
   end

   assign q_sat  = (|quo_ff[SUM_W-1:SAMPLE_W]) ? FULL_SCALE : quo_ff[SAMPLE_W-1:0];
   assign avg_in = cfg.complement_mode ? (FULL_SCALE - q_sat) : q_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) out_avg_ff <= avg_in;
   end

   assign status.out_free = !out_valid_ff || !rsp_stall;
   assign rsp_valid       = out_valid_ff;
   assign rsp_average     = out_avg_ff;

endmodule

// ===== hw/rtl/running_sum_moving_average.sv =====
// top level of the boxcar moving average over a configurable window
//
//   channel   ports                            direction
//   request   req_valid req_stall req_sample   in  (req_stall out)
//   response  rsp_valid rsp_stall rsp_average  out (rsp_stall in)
//   config    psel penable pwrite paddr pwdata in, prdata pready out
//
// each request runs in order from acceptance to a loaded result: the store is
// read at the accepting edge, then comes the sum update, then the
// one-bit-a-cycle divider, then the load of the output register, which waits
// while the previous result is still stalled. a new request is taken once the
// previous result sits in the output register, even if that result is still
// stalled.
// reset needs no clearing pass: a wrap flag and the write position mark which
// store slots have been written, and unwritten slots read as zero.
`timescale 1ns / 1ps

module running_sum_moving_average #(
   parameter int MAX_WINDOW = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rsma_pkg::SAMPLE_W-1:0]       req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rsma_pkg::SAMPLE_W-1:0]       rsp_average,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rsma_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [rsma_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [rsma_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import rsma_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   rsma_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rsma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rsma_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .status      (status),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_average (rsp_average)
   );

endmodule
